// ----- hdl/flight_phase_detector_assert.svh -----
// Assertion macros for the flight phase detector.
// Included by the RTL file that carries concurrent checks; expects clk and rst in scope.
`ifndef FLIGHT_PHASE_DETECTOR_ASSERT_SVH
`define FLIGHT_PHASE_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk and disabled during reset.
`define FPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define FPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FPD_ASSERT_IMP(lbl, ante, cons, msg)
`define FPD_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hdl/fpd_pkg.sv -----
// Shared types and constants of the flight phase detector.
// No dependencies; used by every module of the block.
`default_nettype none

package fpd_pkg;

  // Flight phase codes as they appear on the result.
  typedef enum logic [2:0] {
    PH_INITIAL   = 3'd0,
    PH_ACCEL     = 3'd1,
    PH_COAST     = 3'd2,
    PH_LANDED    = 3'd3,
    PH_FREE_FALL = 3'd4
  } phase_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_THRUST  = 2'd0;
  localparam logic [1:0] REG_COAST   = 2'd1;
  localparam logic [1:0] REG_REST    = 2'd2;
  localparam logic [1:0] REG_DESCENT = 2'd3;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Reset values of the configuration registers.
  localparam logic [14:0]        THRUST_RESET  = 15'd8000;
  localparam logic signed [15:0] COAST_RESET   = -16'sd300;
  localparam logic [14:0]        REST_RESET    = 15'd20;
  localparam logic [7:0]         DESCENT_RESET = 8'd10;

  // Squared thresholds at reset, precomputed.
  localparam logic [29:0] THRUST_SQ_RESET = 30'd64000000;
  localparam logic [29:0] REST_SQ_RESET   = 30'd400;

  localparam logic [7:0] RUN_MAX = 8'd255;

  // One sensor frame.
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [31:0] altitude;
  } frame_t;

  // One result.
  typedef struct packed {
    logic [2:0]         phase;
    logic               apogee_seen;
    logic signed [31:0] apogee_altitude;
  } result_t;

  // Configuration as seen by the datapath; thresholds are kept squared.
  typedef struct packed {
    logic [29:0]        thrust_sq;
    logic [29:0]        rest_sq;
    logic signed [15:0] coast_threshold;
    logic [7:0]         descent_samples;
  } cfg_t;

  // First pipeline stage: per-axis squares plus the fields still needed.
  typedef struct packed {
    logic [30:0]        sq_x;
    logic [30:0]        sq_y;
    logic [30:0]        sq_z;
    logic signed [15:0] accel_z;
    logic signed [31:0] altitude;
  } square_t;

endpackage

`default_nettype wire

// ----- hdl/fpd_cfg.sv -----
// Configuration registers of the flight phase detector.
// Depends on fpd_pkg; squares the magnitude thresholds when they are written.
`default_nettype none

module fpd_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [fpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fpd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output fpd_pkg::cfg_t                         cfg
);
  import fpd_pkg::*;

  logic [29:0] data_sq;

  // One 15x15 multiplier, used only on a write.
  assign data_sq = 30'(cfg_data[14:0]) * 30'(cfg_data[14:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thrust_sq       <= THRUST_SQ_RESET;
      cfg.rest_sq         <= REST_SQ_RESET;
      cfg.coast_threshold <= COAST_RESET;
      cfg.descent_samples <= DESCENT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_THRUST:  cfg.thrust_sq       <= data_sq;
        REG_COAST:   cfg.coast_threshold <= cfg_data;
        REG_REST:    cfg.rest_sq         <= data_sq;
        REG_DESCENT: cfg.descent_samples <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/fpd_square.sv -----
// Input stage of the flight phase detector: registers the squares of the three axes.
// Depends on fpd_pkg.
`default_nettype none

module fpd_square (
  input  wire logic            clk,
  input  wire logic            load,
  input  wire fpd_pkg::frame_t frame,
  output fpd_pkg::square_t     sq
);
  import fpd_pkg::*;

  logic signed [31:0] prod_x;
  logic signed [31:0] prod_y;
  logic signed [31:0] prod_z;

  assign prod_x = frame.accel_x * frame.accel_x;
  assign prod_y = frame.accel_y * frame.accel_y;
  assign prod_z = frame.accel_z * frame.accel_z;

  // A square of a 16-bit value never exceeds 2**30, so 31 bits hold it.
  always_ff @(posedge clk) begin
    if (load) begin
      sq.sq_x     <= prod_x[30:0];
      sq.sq_y     <= prod_y[30:0];
      sq.sq_z     <= prod_z[30:0];
      sq.accel_z  <= frame.accel_z;
      sq.altitude <= frame.altitude;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/fpd_update.sv -----
// Phase and apogee state update plus the result register of the flight phase detector.
// Depends on fpd_pkg and flight_phase_detector_assert.svh.
`default_nettype none

`include "flight_phase_detector_assert.svh"

module fpd_update (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire fpd_pkg::square_t sq,
  input  wire fpd_pkg::cfg_t    cfg,
  input  wire logic             result_ready,
  output logic                  result_valid,
  output fpd_pkg::result_t      result
);
  import fpd_pkg::*;

  phase_t             phase;
  phase_t             phase_next;
  logic               apogee_flag;
  logic               apogee_flag_next;
  logic signed [31:0] apogee_alt;
  logic signed [31:0] apogee_alt_next;
  logic signed [31:0] prev_alt;
  logic [7:0]         run;
  logic [7:0]         run_next;
  logic [31:0]        mag_sq;
  logic               non_rising;

  assign mag_sq     = 32'(sq.sq_x) + 32'(sq.sq_y) + 32'(sq.sq_z);
  assign non_rising = sq.altitude <= prev_alt;

  always_comb begin
    phase_next       = phase;
    apogee_flag_next = apogee_flag;
    apogee_alt_next  = apogee_alt;
    run_next         = run;

    if (mag_sq >= 32'(cfg.thrust_sq)) begin
      phase_next = PH_ACCEL;
    end else if (sq.accel_z < cfg.coast_threshold) begin
      phase_next = PH_COAST;
    end else if (mag_sq <= 32'(cfg.rest_sq)) begin
      phase_next = PH_LANDED;
    end

    if (non_rising) begin
      if (run == 8'd0) begin
        apogee_alt_next = sq.altitude;
      end
      // Free fall is declared only on the step onto the configured count.
      if (run != RUN_MAX) begin
        run_next = run + 8'd1;
        if (run_next == cfg.descent_samples) begin
          phase_next       = PH_FREE_FALL;
          apogee_flag_next = 1'b1;
        end
      end
    end else begin
      run_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_INITIAL;
      apogee_flag  <= 1'b0;
      apogee_alt   <= '0;
      prev_alt     <= '0;
      run          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        phase        <= phase_next;
        apogee_flag  <= apogee_flag_next;
        apogee_alt   <= apogee_alt_next;
        prev_alt     <= sq.altitude;
        run          <= run_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.phase           <= phase_next;
      result.apogee_seen     <= apogee_flag_next;
      result.apogee_altitude <= apogee_alt_next;
    end
  end

  `FPD_ASSERT_NXT(a_flag_sticky, apogee_flag, apogee_flag, "apogee flag was cleared")
  `FPD_ASSERT_IMP(a_flag_rise_ff, $rose(apogee_flag), phase == PH_FREE_FALL, "free fall missing")
  `FPD_ASSERT_IMP(a_flag_rise_run, $rose(apogee_flag), run != 8'd0, "flag rose with empty run")
  `FPD_ASSERT_NXT(a_run_sat, run == RUN_MAX, run == RUN_MAX || run == 8'd0, "run counter wrapped")
  `FPD_ASSERT_IMP(a_result_phase, result_valid, result.phase == phase, "stale result phase")

endmodule

`default_nettype wire

// ----- hdl/flight_phase_detector.sv -----
// Flight phase detector. Each sensor frame (three signed acceleration axes in
// 0.01 m/s^2 and a signed altitude in cm) yields exactly one result: the flight
// phase after that frame, a sticky apogee flag and the captured apogee altitude.
// The block is a two-stage pipeline. The first stage registers the three axis
// squares; the second adds them, compares against the squared thresholds, runs
// the non-rising altitude counter and loads the result register. A new frame
// transaction can be accepted in every cycle in which frame_ready is high, and an
// accepted frame moves from the first stage into the result register as soon as
// that register is empty or being drained; throughput is one frame per cycle,
// limited only by the result consumer. While a finished result waits, the input
// side takes one more frame into the empty first stage and then holds frame_ready
// low until the result is taken; frame_ready follows result_ready within the
// cycle. Thresholds are squared when they are written, so no square root is
// taken. Configuration is written through a plain write port with no wait and
// should only change while no transaction is in flight.
`default_nettype none

module flight_phase_detector (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             frame_valid,
  output logic                                  frame_ready,
  input  wire fpd_pkg::frame_t                  frame,
  output logic                                  result_valid,
  input  wire logic                             result_ready,
  output fpd_pkg::result_t                      result,
  input  wire logic                             cfg_wr_en,
  input  wire logic [fpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fpd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fpd_pkg::*;

  cfg_t    cfg;
  square_t sq;
  logic    sq_valid;
  logic    advance;
  logic    accept;

  // The square stage moves on when the result register is empty or being drained.
  assign advance     = sq_valid && (!result_valid || result_ready);
  assign frame_ready = !sq_valid || advance;
  assign accept      = frame_valid && frame_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (accept) begin
      sq_valid <= 1'b1;
    end else if (advance) begin
      sq_valid <= 1'b0;
    end
  end

  fpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fpd_square u_square (
    .clk   (clk),
    .load  (accept),
    .frame (frame),
    .sq    (sq)
  );

  fpd_update u_update (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .sq           (sq),
    .cfg          (cfg),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire
